// ===== rtl/srpm_pkg.sv =====
package srpm_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int IDX_W        = 10;
	localparam int LEN_W        = 11;
	localparam int LIMIT_W      = 11;
	localparam int ACT_W        = 3;
	localparam int STATUS_W     = 2;
	localparam int MAX_LIST     = 2 ** IDX_W;
	localparam int Q_DEPTH      = 2;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [LIMIT_W-1:0]  limit_t;
	typedef logic [ACT_W-1:0]    act_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam act_t ACT_MERGE     = 3'd0;
	localparam act_t ACT_MERGE_EXT = 3'd1;
	localparam act_t ACT_RESET     = 3'd2;
	localparam act_t ACT_READ      = 3'd3;
	localparam act_t ACT_ADVANCE   = 3'd4;

	localparam status_t STATUS_ADDED   = 2'd0;
	localparam status_t STATUS_PRESENT = 2'd1;
	localparam status_t STATUS_SKIPPED = 2'd2;
	localparam status_t STATUS_DONE    = 2'd3;

	typedef enum logic [2:0] {
		OP_MERGE,
		OP_READ,
		OP_RESET,
		OP_ADVANCE,
		OP_SKIP,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t  op;
		idx_t idx;
		idx_t pos;
	} cmd_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_MARK,
		BS_CHECK,
		BS_READ
	} bstate_t;

endpackage

// ===== rtl/srpm_front.sv =====
module srpm_front #(
	parameter int CAPACITY = srpm_pkg::DEF_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  srpm_pkg::limit_t      cfg_wr_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  srpm_pkg::act_t        action,
	input  srpm_pkg::idx_t        index,
	input  srpm_pkg::idx_t        position,
	input  logic                  q_full,
	output logic                  q_push,
	output srpm_pkg::cmd_t        q_cmd
);

	srpm_pkg::limit_t local_limit_q;
	logic             in_range;
	logic             is_local;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_limit_q <= '0;
		end else if (cfg_wr_en) begin
			local_limit_q <= cfg_wr_data;
		end
	end

	assign in_range   = int'(index) < CAPACITY;
	assign is_local   = srpm_pkg::limit_t'(index) < local_limit_q;
	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	always_comb begin
		q_cmd.idx = index;
		q_cmd.pos = position;
		case (action)
			srpm_pkg::ACT_MERGE: begin
				q_cmd.op = in_range ? srpm_pkg::OP_MERGE : srpm_pkg::OP_SKIP;
			end
			srpm_pkg::ACT_MERGE_EXT: begin
				q_cmd.op = (in_range && !is_local) ? srpm_pkg::OP_MERGE : srpm_pkg::OP_SKIP;
			end
			srpm_pkg::ACT_RESET: begin
				q_cmd.op = srpm_pkg::OP_RESET;
			end
			srpm_pkg::ACT_READ: begin
				q_cmd.op = srpm_pkg::OP_READ;
			end
			srpm_pkg::ACT_ADVANCE: begin
				q_cmd.op = srpm_pkg::OP_ADVANCE;
			end
			default: begin
				q_cmd.op = srpm_pkg::OP_NOP;
			end
		endcase
	end

endmodule

// ===== rtl/srpm_queue.sv =====
module srpm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srpm_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output srpm_pkg::cmd_t head_cmd,
	output logic           empty
);

	localparam int PTR_W = $clog2(srpm_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(srpm_pkg::Q_DEPTH + 1);

	srpm_pkg::cmd_t   slot_q [srpm_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = int'(count_q) == srpm_pkg::Q_DEPTH;
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == srpm_pkg::Q_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == srpm_pkg::Q_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/srpm_back.sv =====
module srpm_back #(
	parameter int CAPACITY = srpm_pkg::DEF_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  srpm_pkg::cmd_t      head_cmd,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                result_valid,
	input  logic                result_stall,
	output srpm_pkg::status_t   status,
	output srpm_pkg::idx_t      entry_index,
	output srpm_pkg::len_t      list_length,
	output srpm_pkg::len_t      level_start,
	output srpm_pkg::len_t      new_count
);

	localparam int DEPTH = (CAPACITY < srpm_pkg::MAX_LIST) ? CAPACITY : srpm_pkg::MAX_LIST;
	localparam int AW    = $clog2(DEPTH);

	typedef logic [AW-1:0] addr_t;

	srpm_pkg::bstate_t state_q;
	srpm_pkg::bstate_t state_d;
	srpm_pkg::cmd_t    cmd_q;
	srpm_pkg::len_t    len_q;
	srpm_pkg::len_t    len_d;
	srpm_pkg::len_t    prev_q;
	srpm_pkg::len_t    prev_d;

	addr_t          mark_mem [DEPTH];
	srpm_pkg::idx_t list_mem [DEPTH];
	addr_t          mark_rd_q;
	srpm_pkg::idx_t list_rd_q;

	logic           mark_re;
	addr_t          mark_ra;
	logic           list_re;
	addr_t          list_ra;
	logic           add_we;
	logic           latch_cmd;
	logic           finish;
	logic           res_free;
	logic           mark_hit;
	logic           list_hit;

	srpm_pkg::status_t res_status;
	srpm_pkg::idx_t    res_entry;
	srpm_pkg::len_t    res_lstart;
	srpm_pkg::len_t    res_ncount;

	logic              res_valid_q;
	srpm_pkg::status_t status_q;
	srpm_pkg::idx_t    entry_q;
	srpm_pkg::len_t    length_q;
	srpm_pkg::len_t    lstart_q;
	srpm_pkg::len_t    ncount_q;

	assign res_free = !res_valid_q || !result_stall;
	assign mark_hit = srpm_pkg::len_t'(mark_rd_q) < len_q;
	assign list_hit = list_rd_q == cmd_q.idx;

	always_comb begin
		state_d = state_q;
		case (state_q)
			srpm_pkg::BS_IDLE: begin
				if (!q_empty) begin
					if (head_cmd.op == srpm_pkg::OP_MERGE) begin
						state_d = srpm_pkg::BS_MARK;
					end else if (head_cmd.op == srpm_pkg::OP_READ) begin
						state_d = srpm_pkg::BS_READ;
					end
				end
			end
			srpm_pkg::BS_MARK: begin
				state_d = srpm_pkg::BS_CHECK;
			end
			srpm_pkg::BS_CHECK, srpm_pkg::BS_READ: begin
				if (res_free) begin
					state_d = srpm_pkg::BS_IDLE;
				end
			end
			default: begin
				state_d = srpm_pkg::BS_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		latch_cmd  = 1'b0;
		mark_re    = 1'b0;
		mark_ra    = head_cmd.idx[AW-1:0];
		list_re    = 1'b0;
		list_ra    = head_cmd.pos[AW-1:0];
		add_we     = 1'b0;
		finish     = 1'b0;
		len_d      = len_q;
		prev_d     = prev_q;
		res_status = srpm_pkg::STATUS_DONE;
		res_entry  = '0;
		res_lstart = '0;
		res_ncount = '0;
		case (state_q)
			srpm_pkg::BS_IDLE: begin
				if (!q_empty) begin
					case (head_cmd.op)
						srpm_pkg::OP_MERGE: begin
							q_pop     = 1'b1;
							latch_cmd = 1'b1;
							mark_re   = 1'b1;
						end
						srpm_pkg::OP_READ: begin
							q_pop     = 1'b1;
							latch_cmd = 1'b1;
							list_re   = 1'b1;
						end
						srpm_pkg::OP_RESET: begin
							if (res_free) begin
								q_pop  = 1'b1;
								finish = 1'b1;
								len_d  = '0;
								prev_d = '0;
							end
						end
						srpm_pkg::OP_ADVANCE: begin
							if (res_free) begin
								q_pop      = 1'b1;
								finish     = 1'b1;
								res_lstart = prev_q;
								res_ncount = len_q - prev_q;
								prev_d     = len_q;
							end
						end
						srpm_pkg::OP_SKIP: begin
							if (res_free) begin
								q_pop      = 1'b1;
								finish     = 1'b1;
								res_status = srpm_pkg::STATUS_SKIPPED;
							end
						end
						default: begin
							if (res_free) begin
								q_pop  = 1'b1;
								finish = 1'b1;
							end
						end
					endcase
				end
			end
			srpm_pkg::BS_MARK: begin
				list_re = 1'b1;
				list_ra = mark_rd_q;
			end
			srpm_pkg::BS_CHECK: begin
				if (res_free) begin
					finish = 1'b1;
					if (mark_hit && list_hit) begin
						res_status = srpm_pkg::STATUS_PRESENT;
					end else if (int'(len_q) >= DEPTH) begin
						res_status = srpm_pkg::STATUS_SKIPPED;
					end else begin
						res_status = srpm_pkg::STATUS_ADDED;
						add_we     = 1'b1;
						len_d      = srpm_pkg::len_t'(len_q + 1'b1);
					end
				end
			end
			srpm_pkg::BS_READ: begin
				if (res_free) begin
					finish = 1'b1;
					if (srpm_pkg::len_t'(cmd_q.pos) < len_q) begin
						res_entry = list_rd_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (add_we) begin
			mark_mem[cmd_q.idx[AW-1:0]] <= len_q[AW-1:0];
		end
		if (mark_re) begin
			mark_rd_q <= mark_mem[mark_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (add_we) begin
			list_mem[len_q[AW-1:0]] <= cmd_q.idx;
		end
		if (list_re) begin
			list_rd_q <= list_mem[list_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (latch_cmd) begin
			cmd_q <= head_cmd;
		end
		if (finish) begin
			status_q <= res_status;
			entry_q  <= res_entry;
			length_q <= len_d;
			lstart_q <= res_lstart;
			ncount_q <= res_ncount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srpm_pkg::BS_IDLE;
			len_q       <= '0;
			prev_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			prev_q  <= prev_d;
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign entry_index  = entry_q;
	assign list_length  = length_q;
	assign level_start  = lstart_q;
	assign new_count    = ncount_q;

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(len_q) <= DEPTH)
		else $error("pattern length exceeds the list depth");

	a_level_order: assert property (@(posedge clk) disable iff (!arst_n)
		prev_q <= len_q)
		else $error("level start lies beyond the pattern length");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (len_q == $past(len_q) || len_q == srpm_pkg::len_t'($past(len_q) + 1'b1)
			|| len_q == '0))
		else $error("pattern length moved by more than one");

	a_mark_then_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == srpm_pkg::BS_MARK |=> state_q == srpm_pkg::BS_CHECK)
		else $error("merge lookup left its sequence");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> res_free)
		else $error("result word overwritten while still held");

endmodule

// ===== rtl/sparse_row_pattern_merge_core.sv =====
// Channel   Valid          Stall          Word
// item      item_valid     item_stall     action, index, position, batch_last
// result    result_valid   result_stall   status, entry_index, list_length,
//                                         level_start, new_count
// config    cfg_wr_en      (none)         cfg_wr_data (local limit)
//
// In the back end a merge steps through a mark memory read, a list memory read to confirm
// the mark, then the update; a list read first reads the list memory; others end in idle.
// A two-word command queue decouples the classifying front end from the back end.
// Reset and the reset command clear the length and level start but not the memories, so
// neither sweeps the mark memory: a mark counts only when the list entry it names points back.
// A held result word stalls the back end; the queue then fills and raises item_stall.
module sparse_row_pattern_merge_core #(
	parameter int CAPACITY = srpm_pkg::DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  srpm_pkg::limit_t  cfg_wr_data,
	input  logic              item_valid,
	output logic              item_stall,
	input  srpm_pkg::act_t    action,
	input  srpm_pkg::idx_t    index,
	input  srpm_pkg::idx_t    position,
	input  logic              batch_last,
	output logic              result_valid,
	input  logic              result_stall,
	output srpm_pkg::status_t status,
	output srpm_pkg::idx_t    entry_index,
	output srpm_pkg::len_t    list_length,
	output srpm_pkg::len_t    level_start,
	output srpm_pkg::len_t    new_count
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	srpm_pkg::cmd_t push_cmd;
	srpm_pkg::cmd_t head_cmd;

	srpm_front #(
		.CAPACITY (CAPACITY)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.action      (action),
		.index       (index),
		.position    (position),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd)
	);

	srpm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty)
	);

	srpm_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_cmd     (head_cmd),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.entry_index  (entry_index),
		.list_length  (list_length),
		.level_start  (level_start),
		.new_count    (new_count)
	);

endmodule

// ===== bench/srpm_reply_checker.sv =====
`timescale 1ns / 100ps

module srpm_reply_checker #(
	parameter int CAPACITY = srpm_pkg::DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  srpm_pkg::limit_t  cfg_wr_data,
	input  logic              item_valid,
	input  logic              item_stall,
	input  srpm_pkg::act_t    action,
	input  srpm_pkg::idx_t    index,
	input  srpm_pkg::idx_t    position,
	input  logic              result_valid,
	input  logic              result_stall,
	input  srpm_pkg::status_t status,
	input  srpm_pkg::idx_t    entry_index,
	input  srpm_pkg::len_t    list_length,
	input  srpm_pkg::len_t    level_start,
	input  srpm_pkg::len_t    new_count,
	output int                mismatches,
	output int                replies_pending,
	output int                replies_checked,
	output int                indices_added,
	output int                peak_length
);

	typedef struct packed {
		srpm_pkg::status_t status;
		srpm_pkg::idx_t    entry;
		srpm_pkg::len_t    length;
		srpm_pkg::len_t    lstart;
		srpm_pkg::len_t    ncount;
	} pattern_reply_t;

	bit               in_pattern [srpm_pkg::MAX_LIST];
	srpm_pkg::idx_t   column_at [srpm_pkg::MAX_LIST];
	srpm_pkg::len_t   pattern_len;
	srpm_pkg::len_t   level_base;
	srpm_pkg::limit_t skip_below;
	pattern_reply_t   awaited_replies [$];
	pattern_reply_t   got;
	pattern_reply_t   want;
	int               err_total;
	int               pending_cnt;
	int               checked_cnt;
	int               added_cnt;
	int               peak_cnt;

	assign mismatches      = err_total;
	assign replies_pending = pending_cnt;
	assign replies_checked = checked_cnt;
	assign indices_added   = added_cnt;
	assign peak_length     = peak_cnt;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_total++;
	endtask

	function automatic srpm_pkg::status_t append_column(input srpm_pkg::idx_t ix);
		if (ix >= CAPACITY)
			return srpm_pkg::STATUS_SKIPPED;
		if (in_pattern[ix])
			return srpm_pkg::STATUS_PRESENT;
		if (pattern_len >= CAPACITY)
			return srpm_pkg::STATUS_SKIPPED;
		in_pattern[ix] = 1'b1;
		column_at[pattern_len[srpm_pkg::IDX_W-1:0]] = ix;
		pattern_len++;
		return srpm_pkg::STATUS_ADDED;
	endfunction

	function automatic pattern_reply_t merge_word(input srpm_pkg::act_t a,
		input srpm_pkg::idx_t ix, input srpm_pkg::idx_t ps);
		pattern_reply_t r;
		r = '0;
		r.status = srpm_pkg::STATUS_DONE;
		case (a)
			srpm_pkg::ACT_MERGE: begin
				r.status = append_column(ix);
			end
			srpm_pkg::ACT_MERGE_EXT: begin
				if (ix < skip_below)
					r.status = srpm_pkg::STATUS_SKIPPED;
				else
					r.status = append_column(ix);
			end
			srpm_pkg::ACT_RESET: begin
				for (int i = 0; i < pattern_len && i < CAPACITY; i++)
					in_pattern[column_at[i]] = 1'b0;
				pattern_len = '0;
				level_base = '0;
			end
			srpm_pkg::ACT_READ: begin
				if (ps < pattern_len && ps < CAPACITY)
					r.entry = column_at[ps];
			end
			srpm_pkg::ACT_ADVANCE: begin
				r.lstart = level_base;
				r.ncount = pattern_len - level_base;
				level_base = pattern_len;
			end
			default: begin
			end
		endcase
		r.length = pattern_len;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srpm_pkg::MAX_LIST; i++)
				in_pattern[i] = 1'b0;
			pattern_len = '0;
			level_base = '0;
			skip_below = '0;
			awaited_replies.delete();
			pending_cnt = 0;
		end else begin
			if (cfg_wr_en)
				skip_below = cfg_wr_data;
			if (item_valid && !item_stall)
				awaited_replies.push_back(merge_word(action, index, position));
			if (result_valid && !result_stall) begin
				got = {status, entry_index, list_length, level_start, new_count};
				if (awaited_replies.size() == 0) begin
					report_mismatch("result word arrived with nothing predicted");
				end else begin
					want = awaited_replies.pop_front();
					checked_cnt++;
					if (got.status !== want.status)
						report_mismatch($sformatf("status got %0d, expected %0d",
							got.status, want.status));
					if (got.entry !== want.entry)
						report_mismatch($sformatf("entry_index got %0d, expected %0d",
							got.entry, want.entry));
					if (got.length !== want.length)
						report_mismatch($sformatf("list_length got %0d, expected %0d",
							got.length, want.length));
					if (got.lstart !== want.lstart)
						report_mismatch($sformatf("level_start got %0d, expected %0d",
							got.lstart, want.lstart));
					if (got.ncount !== want.ncount)
						report_mismatch($sformatf("new_count got %0d, expected %0d",
							got.ncount, want.ncount));
					if (want.status == srpm_pkg::STATUS_ADDED)
						added_cnt++;
					if (int'(want.length) > peak_cnt)
						peak_cnt = int'(want.length);
				end
			end
			pending_cnt = awaited_replies.size();
		end
	end

endmodule

// ===== bench/tb_sparse_row_pattern_merge_core.sv =====
`timescale 1ns / 100ps

module tb_sparse_row_pattern_merge_core;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_wr_en    = 1'b0;
	srpm_pkg::limit_t  cfg_wr_data  = '0;
	logic              item_valid   = 1'b0;
	srpm_pkg::act_t    action       = srpm_pkg::ACT_MERGE;
	srpm_pkg::idx_t    index        = '0;
	srpm_pkg::idx_t    position     = '0;
	logic              batch_last   = 1'b0;
	logic              result_stall = 1'b0;
	logic              item_stall;
	logic              result_valid;
	srpm_pkg::status_t status;
	srpm_pkg::idx_t    entry_index;
	srpm_pkg::len_t    list_length;
	srpm_pkg::len_t    level_start;
	srpm_pkg::len_t    new_count;

	int             mismatches;
	int             replies_pending;
	int             replies_checked;
	int             indices_added;
	int             peak_length;
	int             gap_pct   = 0;
	int             stall_pct = 0;
	int             words_sent = 0;
	int             cur_limit = 0;
	srpm_pkg::idx_t prev_index = '0;
	int             limit_set [6] = '{0, 1024, 0, 512, 1, 1023};

	sparse_row_pattern_merge_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.index        (index),
		.position     (position),
		.batch_last   (batch_last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.entry_index  (entry_index),
		.list_length  (list_length),
		.level_start  (level_start),
		.new_count    (new_count)
	);

	srpm_reply_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.action          (action),
		.index           (index),
		.position        (position),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.status          (status),
		.entry_index     (entry_index),
		.list_length     (list_length),
		.level_start     (level_start),
		.new_count       (new_count),
		.mismatches      (mismatches),
		.replies_pending (replies_pending),
		.replies_checked (replies_checked),
		.indices_added   (indices_added),
		.peak_length     (peak_length)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_word(input srpm_pkg::act_t a, input srpm_pkg::idx_t ix,
		input srpm_pkg::idx_t ps, input logic bl);
		bit held;
		while ($urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= a;
		index <= ix;
		position <= ps;
		batch_last <= bl;
		do begin
			@(negedge clk);
			held = item_stall;
			@(posedge clk);
		end while (held);
		words_sent++;
	endtask

	task automatic drain_replies();
		item_valid <= 1'b0;
		do @(negedge clk); while (replies_pending != 0);
		@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input int v);
		drain_replies();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= srpm_pkg::limit_t'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_limit = v;
	endtask

	task automatic send_random_word();
		int             sel;
		srpm_pkg::act_t a;
		srpm_pkg::idx_t ix;
		srpm_pkg::idx_t ps;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			ix = srpm_pkg::idx_t'($urandom_range(0, 63));
		else if (sel < 55)
			ix = prev_index;
		else
			ix = srpm_pkg::idx_t'($urandom_range(0, 1023));
		if ($urandom_range(0, 99) < 70)
			ps = srpm_pkg::idx_t'($urandom_range(0, 47));
		else
			ps = srpm_pkg::idx_t'($urandom_range(0, 1023));
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			a = srpm_pkg::ACT_MERGE;
		end else if (sel < 62) begin
			a = srpm_pkg::ACT_MERGE_EXT;
			if (cur_limit <= 1023 && $urandom_range(0, 1))
				ix = srpm_pkg::idx_t'($urandom_range(cur_limit, 1023));
		end else if (sel < 66) begin
			a = srpm_pkg::ACT_RESET;
		end else if (sel < 84) begin
			a = srpm_pkg::ACT_READ;
		end else if (sel < 94) begin
			a = srpm_pkg::ACT_ADVANCE;
		end else begin
			a = srpm_pkg::act_t'($urandom_range(srpm_pkg::ACT_ADVANCE + 1,
				2 ** srpm_pkg::ACT_W - 1));
		end
		send_word(a, ix, ps, $urandom_range(0, 3) == 0);
		prev_index = ix;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 10;
		stall_pct = 69;
		send_word(srpm_pkg::ACT_READ, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_ADVANCE, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, 10'd0, 10'd1023, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, 10'd1023, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, 10'd1023, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE_EXT, 10'd512, 10'd0, 1'b1);
		send_word(srpm_pkg::ACT_READ, 10'd1023, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_READ, 10'd0, 10'd1, 1'b0);
		send_word(srpm_pkg::ACT_READ, 10'd0, 10'd2, 1'b0);
		send_word(srpm_pkg::ACT_READ, 10'd0, 10'd3, 1'b0);
		send_word(srpm_pkg::ACT_READ, 10'd0, 10'd1023, 1'b0);
		send_word(srpm_pkg::ACT_ADVANCE, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, 10'd5, 10'd0, 1'b1);
		send_word(srpm_pkg::ACT_ADVANCE, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::act_t'(srpm_pkg::ACT_ADVANCE + 1), 10'd1023, 10'd1023, 1'b1);
		send_word(srpm_pkg::act_t'(srpm_pkg::ACT_ADVANCE + 2), 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::act_t'(srpm_pkg::ACT_ADVANCE + 3), 10'd1023, 10'd1023, 1'b1);
		send_word(srpm_pkg::ACT_RESET, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_READ, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, 10'd1023, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, 10'd1023, 10'd0, 1'b1);
		send_word(srpm_pkg::ACT_ADVANCE, 10'd0, 10'd0, 1'b0);
		write_limit(1024);
		send_word(srpm_pkg::ACT_MERGE_EXT, 10'd1023, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, 10'd7, 10'd0, 1'b1);
		write_limit(1);
		send_word(srpm_pkg::ACT_MERGE_EXT, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE_EXT, 10'd1, 10'd0, 1'b1);

		limit_set[2] = int'($urandom_range(2, 1022));
		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				gap_pct = 10;
				stall_pct = 69;
			end else if (p < 4) begin
				gap_pct = 69;
				stall_pct = 10;
			end else begin
				gap_pct = 0;
				stall_pct = 0;
			end
			write_limit(limit_set[p]);
			repeat (70) send_random_word();
		end

		gap_pct = 0;
		stall_pct = 0;
		write_limit(0);
		send_word(srpm_pkg::ACT_READ, 10'd0, 10'd1023, 1'b0);
		send_word(srpm_pkg::ACT_READ, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, srpm_pkg::idx_t'($urandom_range(0, 1023)), 10'd0,
			1'b0);
		send_word(srpm_pkg::ACT_ADVANCE, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_ADVANCE, 10'd0, 10'd0, 1'b0);
		write_limit(1024);
		send_word(srpm_pkg::ACT_MERGE_EXT, 10'd1023, 10'd0, 1'b1);
		send_word(srpm_pkg::ACT_RESET, 10'd0, 10'd0, 1'b0);
		send_word(srpm_pkg::ACT_READ, 10'd0, 10'd1023, 1'b0);
		send_word(srpm_pkg::ACT_MERGE, 10'd0, 10'd0, 1'b0);

		drain_replies();
		$display("Sent %0d item words and checked %0d result words.", words_sent,
			replies_checked);
		$display("%0d merges added a column; the pattern peaked at %0d columns.",
			indices_added, peak_length);
		if (mismatches == 0 && replies_pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
